FILE: rtl/bkhc_pkg.sv
// ----------------------------------------------------------------------------
// Bitset keyed hash cache package
// Shared constants, field widths and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bkhc_pkg;

  localparam int MAX_UNIVERSE_DEF = 256;
  localparam int NUM_SLOTS_DEF    = 1024;
  localparam int BUCKET_DEPTH_DEF = 8;
  localparam int VALUE_WIDTH_DEF  = 16;

  localparam int UNIV_W    = 9;
  localparam int ELEM_W    = 8;
  localparam int DEPTH_W   = 4;
  localparam int COUNT_W   = 9;
  localparam int STATUS_W  = 3;

  localparam logic [31:0]          HASH_MUL  = 32'he2148403;
  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [UNIV_W-1:0]    UNIV_RST  = 9'd256;

  typedef enum logic [0:0] {
    OP_SEARCH = 1'b0,
    OP_ADD    = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MISS   = 3'd0,
    ST_HIT    = 3'd1,
    ST_STORED = 3'd2,
    ST_FULL   = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/bkhc_if.sv
// ----------------------------------------------------------------------------
// Bitset keyed hash cache channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bkhc_in_if #(
  parameter int VALUE_WIDTH = bkhc_pkg::VALUE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [bkhc_pkg::ELEM_W-1:0]    element;
  logic                           element_valid;
  logic                           last_element;
  logic [bkhc_pkg::DEPTH_W-1:0]   tree_depth;
  logic [VALUE_WIDTH-1:0]         value_in;

  modport source (output valid, opcode, element, element_valid, last_element,
                  tree_depth, value_in, input ready);
  modport sink   (input valid, opcode, element, element_valid, last_element,
                  tree_depth, value_in, output ready);
endinterface

interface bkhc_out_if #(
  parameter int VALUE_WIDTH = bkhc_pkg::VALUE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [bkhc_pkg::STATUS_W-1:0]  status;
  logic [VALUE_WIDTH-1:0]         value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink   (input valid, status, value_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/bitset_keyed_hash_cache_unit.sv
// ----------------------------------------------------------------------------
// Bitset keyed hash cache
// Set-keyed cache with a multiplicative word hash and fixed-depth buckets.
// ----------------------------------------------------------------------------
// Items that carry set elements are taken one per cycle while the unit is idle.
// A closing item is followed by hashing, one word per cycle over the words the
// universe covers, forming the slot, reading the bucket fill, then on a search
// reading and comparing entries until a match or the last one, and handing the
// result to the output register; an add takes no walk, and an element out of
// range goes straight to the result. The bucket fill memory is cleared after
// reset; no item is taken during that pass. NUM_SLOTS must be a power of two.
`default_nettype none

module bitset_keyed_hash_cache_unit #(
  parameter int MAX_UNIVERSE = bkhc_pkg::MAX_UNIVERSE_DEF,
  parameter int NUM_SLOTS    = bkhc_pkg::NUM_SLOTS_DEF,
  parameter int BUCKET_DEPTH = bkhc_pkg::BUCKET_DEPTH_DEF,
  parameter int VALUE_WIDTH  = bkhc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [bkhc_pkg::UNIV_W-1:0]  cfg_wdata,
  bkhc_in_if.sink                           in_ch,
  bkhc_out_if.source                        out_ch
);

  localparam int KEY_WORDS = (MAX_UNIVERSE + 31) / 32;
  localparam int KW_IDX    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int NW_W      = $clog2(KEY_WORDS + 1);
  localparam int KEY_BITS  = KEY_WORDS * 32;
  localparam int EU_W      = ($clog2(MAX_UNIVERSE + 1) > bkhc_pkg::UNIV_W) ?
                             $clog2(MAX_UNIVERSE + 1) : bkhc_pkg::UNIV_W;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int FW        = $clog2(BUCKET_DEPTH + 1);
  localparam int ADDR_W    = $clog2(NUM_SLOTS * BUCKET_DEPTH);
  localparam int ENT_W     = VALUE_WIDTH + bkhc_pkg::DEPTH_W + bkhc_pkg::COUNT_W
                             + KEY_BITS;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_HASH = 8'b0000_0100,
    S_FILL = 8'b0000_1000,
    S_LOOK = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_CMP  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                         state, state_next;
  logic [bkhc_pkg::UNIV_W-1:0]    universe;
  logic [31:0]                    key_words [KEY_WORDS];
  logic [bkhc_pkg::COUNT_W-1:0]   elem_count;
  logic                           range_error;
  logic                           op;
  logic [bkhc_pkg::DEPTH_W-1:0]   depth;
  logic [VALUE_WIDTH-1:0]         value;
  logic [31:0]                    hash;
  logic [NW_W-1:0]                hcnt;
  logic [SLOT_W-1:0]              slot;
  logic [SLOT_W-1:0]              clr_cnt;
  logic [FW-1:0]                  fill_rd;
  logic [FW-1:0]                  idx;
  logic [ENT_W-1:0]               ent_rd;
  logic [bkhc_pkg::STATUS_W-1:0]  res_status;
  logic [VALUE_WIDTH-1:0]         res_value;
  logic                           out_valid;
  logic [bkhc_pkg::STATUS_W-1:0]  out_status;
  logic [VALUE_WIDTH-1:0]         out_value;

  // Memories.
  logic [FW-1:0]                  fill_mem [NUM_SLOTS];
  logic [ENT_W-1:0]               ent_mem  [NUM_SLOTS * BUCKET_DEPTH];

  logic [EU_W-1:0]                eff_univ;
  logic [EU_W:0]                  univ_round;
  logic [NW_W-1:0]                nwords;
  logic                           accept;
  logic                           in_range;
  logic                           err_now;
  logic                           out_free;
  logic [KEY_BITS-1:0]            key_flat;
  logic [ADDR_W-1:0]              ent_addr;
  logic                           fill_we;
  logic [SLOT_W-1:0]              fill_waddr;
  logic [FW-1:0]                  fill_wdata;
  logic                           ent_we;
  logic                           match;
  logic [31:0]                    hash_sum;

  assign eff_univ   = (EU_W'(universe) > EU_W'(MAX_UNIVERSE)) ? EU_W'(MAX_UNIVERSE)
                                                               : EU_W'(universe);
  assign univ_round = (EU_W+1)'(eff_univ) + (EU_W+1)'(31);
  assign nwords     = NW_W'(univ_round >> 5);
  assign accept     = in_ch.valid && in_ch.ready;
  assign in_range   = (EU_W'(in_ch.element) < eff_univ) &&
                      ((32'(in_ch.element) >> 5) < 32'(KEY_WORDS));
  assign err_now    = range_error || (in_ch.element_valid && !in_range);
  assign out_free   = !out_valid || out_ch.ready;
  assign ent_addr   = ADDR_W'(slot * BUCKET_DEPTH) + ADDR_W'(ent_we ? fill_rd : idx);
  assign hash_sum   = hash + key_words[hcnt[KW_IDX-1:0]];

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      key_flat[i*32 +: 32] = key_words[i];
    end
  end

  // Only the words covered by the current universe take part in a match.
  always_comb begin
    match = (ent_rd[KEY_BITS +: bkhc_pkg::COUNT_W] == elem_count) &&
            (ent_rd[KEY_BITS + bkhc_pkg::COUNT_W +: bkhc_pkg::DEPTH_W] == depth);
    for (int i = 0; i < KEY_WORDS; i++) begin
      if ((NW_W+1)'(i) < (NW_W+1)'(nwords) && ent_rd[i*32 +: 32] != key_words[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = slot;
    fill_wdata = fill_rd + FW'(1);
    ent_we     = 1'b0;
    if (state == S_CLR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt;
      fill_wdata = '0;
    end else if (state == S_LOOK && op == bkhc_pkg::OP_ADD &&
                 32'(fill_rd) < 32'(BUCKET_DEPTH)) begin
      fill_we = 1'b1;
      ent_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rd <= fill_mem[slot];
  end

  // In the add case the fill level selects the free entry of the bucket.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= {value, depth, elem_count, key_flat};
    end
    ent_rd <= ent_mem[ent_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_cnt == SLOT_W'(NUM_SLOTS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept && in_ch.last_element) begin
          state_next = err_now ? S_DONE : S_HASH;
        end
      end
      S_HASH: if (hcnt == nwords) state_next = S_FILL;
      S_FILL: state_next = S_LOOK;
      S_LOOK: begin
        if (op == bkhc_pkg::OP_ADD || fill_rd == '0) state_next = S_DONE;
        else state_next = S_RD;
      end
      S_RD:   state_next = S_CMP;
      S_CMP: begin
        if (match || idx + FW'(1) == fill_rd) state_next = S_DONE;
        else state_next = S_RD;
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_cnt     <= '0;
      universe    <= bkhc_pkg::UNIV_RST;
      elem_count  <= '0;
      range_error <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_words[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        universe <= cfg_wdata;
      end
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.element_valid) begin
              if (in_range) begin
                key_words[KW_IDX'(in_ch.element >> 5)][in_ch.element[4:0]] <= 1'b1;
              end else begin
                range_error <= 1'b1;
              end
              if (elem_count != bkhc_pkg::COUNT_MAX) begin
                elem_count <= elem_count + bkhc_pkg::COUNT_W'(1);
              end
            end
            op         <= in_ch.opcode;
            depth      <= in_ch.tree_depth;
            value      <= in_ch.value_in;
            hash       <= bkhc_pkg::HASH_MUL;
            hcnt       <= '0;
            res_status <= bkhc_pkg::ST_RANGE;
            res_value  <= '0;
          end
        end
        S_HASH: begin
          if (hcnt == nwords) begin
            slot <= SLOT_W'(hash + 32'(depth));
          end else begin
            hash <= hash_sum * bkhc_pkg::HASH_MUL;
            hcnt <= hcnt + NW_W'(1);
          end
        end
        S_LOOK: begin
          idx <= '0;
          if (op == bkhc_pkg::OP_ADD) begin
            res_status <= (32'(fill_rd) < 32'(BUCKET_DEPTH)) ? bkhc_pkg::ST_STORED
                                                             : bkhc_pkg::ST_FULL;
          end else begin
            res_status <= bkhc_pkg::ST_MISS;
          end
        end
        S_CMP: begin
          if (match) begin
            res_status <= bkhc_pkg::ST_HIT;
            res_value  <= ent_rd[ENT_W-1 -: VALUE_WIDTH];
          end
          idx <= idx + FW'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_status  <= res_status;
            out_value   <= res_value;
            elem_count  <= '0;
            range_error <= 1'b0;
            for (int i = 0; i < KEY_WORDS; i++) begin
              key_words[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Items are taken only while the unit waits for the next element.
  always_comb begin
    in_ch.ready      = (state == S_IDLE);
    out_ch.valid     = out_valid;
    out_ch.status    = out_status;
    out_ch.value_out = out_value;
  end

endmodule

`default_nettype wire

FILE: rtl/bkhc_checker.sv
// ----------------------------------------------------------------------------
// Bitset keyed hash cache checker
// Port-level properties of the cache, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bkhc_checker (
  input wire logic    clk,
  input wire logic    rst,
  bkhc_in_if.sink     in_ch,
  bkhc_out_if.source  out_ch
);

  // A result that waits keeps its status until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result changed while stalled");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != bkhc_pkg::ST_HIT |-> out_ch.value_out == '0)
    else $error("value shown on a result that is not a hit");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.status <= bkhc_pkg::ST_RANGE)
    else $error("undefined status code");

  // The fill memory is swept after reset before any item is taken.
  a_clear_pass: assert property (@(posedge clk)
    rst |=> !in_ch.ready)
    else $error("input taken during the clearing pass");

endmodule

bind bitset_keyed_hash_cache_unit bkhc_checker u_bkhc_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire
